// ===== design/bmd_pkg.sv =====
// Shared constants and types for the 5x5 disc binary morphology block.
package bmd_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_OP_MODE      = 2'd0;
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd2;

   // Operating modes
   localparam logic MODE_ERODE  = 1'b0;
   localparam logic MODE_DILATE = 1'b1;

   // Configuration reset values
   localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
   localparam logic [10:0] FRAME_HEIGHT_RST = 11'd480;
   localparam int          MIN_SIZE         = 5;

   // Pixel levels
   localparam logic [7:0] PIX_ON  = 8'd255;
   localparam logic [7:0] PIX_OFF = 8'd0;

   // Window bit (dy, dx) sits at (2 - dx) * 5 + (dy + 2); the disc leaves out the corners
   localparam logic [24:0] DISC_MASK = 25'h0EFFFEE;

   // Output queue
   localparam int RSP_DEPTH = 3;

   typedef struct packed {
      logic frame_end;
      logic hit;
   } rsp_entry_type;

endpackage

// ===== design/bmd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bmd_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read at the address being written returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/binary_morphology_disc5x5.sv =====
// Streaming binary erosion and dilation over a 5x5 disc with line memory.
//
//   channel  dir  ports                         payload (low bit first)
//   -------  ---  ----------------------------  ---------------------------------
//   req      in   req_tvalid/tready/tdata/tuser tdata: pixel_in[7:0]; tuser: pad
//   rsp      out  rsp_tvalid/tready/tdata/tlast tdata: pixel_out[7:0]; tlast: frame_end
//   csr      in   csr_valid/ready/index/data    index 0 op_mode, 1 frame_width,
//                                               2 frame_height
//
// One pixel transfer per cycle while rsp keeps taking results. Each transfer reads one
// column word (the four previous rows of that column) from the line memory and writes the
// shifted word back in the next cycle; that read-modify-write on the single line memory
// sets the rate. A result passes the stage 1 registers and the output queue before it
// can transfer on rsp.
// Reset clears control state; the line memory is never swept, a fill count makes columns
// not yet written since reset read as zero.
// A stalled rsp side fills a three-entry output queue, then req_tready drops.
module binary_morphology_disc5x5
   import bmd_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // input pixel stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_in
   input  logic        req_tuser,   // [0] pad
   // result pixel stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] pixel_out
   output logic        rsp_tlast,   // frame_end
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   localparam int CB  = $clog2(MAX_WIDTH);        // column index bits
   localparam int WB  = $clog2(MAX_WIDTH + 1);    // width value bits
   localparam int HB  = $clog2(MAX_HEIGHT + 1);   // height value bits
   localparam int RB  = $clog2(MAX_HEIGHT + 4);   // row counter, runs past the frame on flush
   localparam int SB  = ((RB > WB) ? RB : WB) + 2; // signed centre coordinates
   localparam int QB  = $clog2(RSP_DEPTH);
   localparam int QCB = $clog2(RSP_DEPTH + 1);

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic        op_mode_ff;
   logic [10:0] frame_width_ff;
   logic [10:0] frame_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff      <= MODE_ERODE;
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OP_MODE:      op_mode_ff      <= csr_data[0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // Saturate the frame size into the supported range
   logic [WB-1:0] w_eff;
   logic [HB-1:0] h_eff;

   always_comb begin
      if (32'(frame_width_ff) < MIN_SIZE) begin
         w_eff = WB'(MIN_SIZE);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_eff = WB'(MAX_WIDTH);
      end else begin
         w_eff = WB'(frame_width_ff);
      end
      if (32'(frame_height_ff) < MIN_SIZE) begin
         h_eff = HB'(MIN_SIZE);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         h_eff = HB'(MAX_HEIGHT);
      end else begin
         h_eff = HB'(frame_height_ff);
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 0: input position, line memory read
   // ---------------------------------------------------------------------------------
   logic [CB-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;
   logic [WB-1:0] fill_ff, fill_in;

   logic          req_xfer;
   logic          pos_restart;
   logic [CB-1:0] col_base, col_cur;
   logic [RB-1:0] row_base, row_cur;
   logic          frame_restart;
   logic          active;
   logic          pix_bit;
   logic          emit;
   logic          frame_last;
   logic [SB-1:0] cy_cur, cx_cur;

   // stage 1 registers
   logic          s1_valid_ff;
   logic          s1_bit_ff;
   logic [CB-1:0] s1_addr_ff;
   logic          s1_emit_ff;
   logic [SB-1:0] s1_cy_ff;
   logic [SB-1:0] s1_cx_ff;
   logic          s1_fwd_ff;
   logic [3:0]    s1_fwd_data_ff;
   logic          s1_known_ff;

   logic [3:0]    ram_rd_data;
   logic [3:0]    mem_word;
   logic [3:0]    word_new;

   assign req_xfer = req_tvalid && req_tready;

   always_comb begin
      // position out of range after a size change, or flush ran past its end
      pos_restart = (32'(col_ff) >= 32'(w_eff)) || (32'(row_ff) > 32'(h_eff) + 2);
      col_base    = pos_restart ? '0 : col_ff;
      row_base    = pos_restart ? '0 : row_ff;

      // a pixel after the last frame row starts a new frame
      frame_restart = !req_tuser && (32'(row_base) >= 32'(h_eff));
      // a pad inside a frame carries no work
      active        = req_xfer && (!req_tuser || (32'(row_base) >= 32'(h_eff)));

      col_cur = frame_restart ? '0 : col_base;
      row_cur = frame_restart ? '0 : row_base;

      if (req_tuser) begin
         pix_bit = 1'b0;
      end else if (op_mode_ff == MODE_DILATE) begin
         pix_bit = (req_tdata != PIX_OFF);
      end else begin
         pix_bit = (req_tdata == PIX_ON);
      end

      // window is full once the position reaches 2*width + 2
      emit = (32'(row_cur) >= 3) || ((32'(row_cur) == 2) && (32'(col_cur) >= 2));

      // centre of the window, wrapped back one row in the first two columns
      if (32'(col_cur) >= 2) begin
         cy_cur = SB'(row_cur) - SB'(2);
         cx_cur = SB'(col_cur) - SB'(2);
      end else begin
         cy_cur = SB'(row_cur) - SB'(3);
         cx_cur = SB'(col_cur) + SB'(w_eff) - SB'(2);
      end

      // the result for the frame's last pixel closes the frame; rewind to its origin
      frame_last = emit && (cy_cur == SB'(h_eff) - SB'(1)) && (cx_cur == SB'(w_eff) - SB'(1));

      col_in = col_ff;
      row_in = row_ff;
      if (req_xfer) begin
         if (!active) begin
            col_in = col_base;
            row_in = row_base;
         end else if (frame_last) begin
            col_in = '0;
            row_in = '0;
         end else if (32'(col_cur) + 1 == 32'(w_eff)) begin
            col_in = '0;
            row_in = row_cur + RB'(1);
         end else begin
            col_in = col_cur + CB'(1);
            row_in = row_cur;
         end
      end

      // columns ever written form a prefix; grow it on a write at its end
      fill_in = fill_ff;
      if (s1_valid_ff && (32'(s1_addr_ff) == 32'(fill_ff))) begin
         fill_in = fill_ff + WB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         fill_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         fill_ff     <= fill_in;
         s1_valid_ff <= active;
      end
   end

   // Stage 1 payload; forward the word being written when the read hits the same column
   always_ff @(posedge clock) begin
      if (active) begin
         s1_bit_ff      <= pix_bit;
         s1_addr_ff     <= col_cur;
         s1_emit_ff     <= emit;
         s1_cy_ff       <= cy_cur;
         s1_cx_ff       <= cx_cur;
         s1_fwd_ff      <= s1_valid_ff && (s1_addr_ff == col_cur);
         s1_fwd_data_ff <= word_new;
         s1_known_ff    <= (32'(col_cur) < 32'(fill_ff));
      end
   end

   // Line memory: one word per column, bit 0 the newest row, bit 3 the oldest
   bmd_ram #(
      .WIDTH (4),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (word_new),
      .rd_en   (active),
      .rd_addr (col_cur),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------------------
   // Stage 1: column update, window shift, disc evaluation
   // ---------------------------------------------------------------------------------
   logic [24:0]   window_ff, window_in;
   logic [4:0]    col_bits;
   logic [4:0]    row_ok, col_ok;
   logic [24:0]   inner_mask;
   logic [SB-1:0] y_probe, x_probe;
   logic          erode_hit, dilate_hit;
   logic          hit;
   logic          frame_end;

   always_comb begin
      if (s1_fwd_ff) begin
         mem_word = s1_fwd_data_ff;
      end else if (s1_known_ff) begin
         mem_word = ram_rd_data;
      end else begin
         mem_word = 4'b0000;
      end

      // oldest row in bit 0, current pixel in bit 4
      col_bits  = {s1_bit_ff, mem_word[0], mem_word[1], mem_word[2], mem_word[3]};
      word_new  = {mem_word[2:0], s1_bit_ff};
      window_in = s1_valid_ff ? {window_ff[19:0], col_bits} : window_ff;

      // interior test for every row and column offset of the window
      for (int k = 0; k < 5; k++) begin
         y_probe   = s1_cy_ff + SB'(k) - SB'(2);
         x_probe   = s1_cx_ff + SB'(k) - SB'(2);
         row_ok[k] = ($signed(y_probe) >= $signed(SB'(2)))
                     && ($signed(y_probe) <= $signed(SB'(h_eff) - SB'(3)));
         col_ok[k] = ($signed(x_probe) >= $signed(SB'(2)))
                     && ($signed(x_probe) <= $signed(SB'(w_eff) - SB'(3)));
      end

      // column age a holds offset dx = 2 - a
      for (int a = 0; a < 5; a++) begin
         for (int r = 0; r < 5; r++) begin
            inner_mask[a * 5 + r] = row_ok[r] && col_ok[4 - a];
         end
      end

      erode_hit  = row_ok[2] && col_ok[2] && (&(window_in | ~DISC_MASK));
      dilate_hit = |(window_in & DISC_MASK & inner_mask);
      hit        = (op_mode_ff == MODE_DILATE) ? dilate_hit : erode_hit;

      frame_end = (s1_cy_ff == SB'(h_eff) - SB'(1)) && (s1_cx_ff == SB'(w_eff) - SB'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Output queue
   // ---------------------------------------------------------------------------------
   rsp_entry_type  rsp_q_ff [RSP_DEPTH];
   logic [QB-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QB-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCB-1:0] q_cnt_ff, q_cnt_in;
   logic           push, pop;
   rsp_entry_type  head;

   always_comb begin
      push = s1_valid_ff && s1_emit_ff;
      pop  = rsp_tvalid && rsp_tready;

      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == RSP_DEPTH - 1) ? '0 : wr_ptr_ff + QB'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == RSP_DEPTH - 1) ? '0 : rd_ptr_ff + QB'(1);
      end

      q_cnt_in = q_cnt_ff;
      if (push && !pop) begin
         q_cnt_in = q_cnt_ff + QCB'(1);
      end else if (pop && !push) begin
         q_cnt_in = q_cnt_ff - QCB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_q_ff[wr_ptr_ff] <= '{frame_end: frame_end, hit: hit};
      end
   end

   // hold input while the queue plus the item in flight could overflow
   assign req_tready = (32'(q_cnt_ff) + 32'(s1_valid_ff)) < RSP_DEPTH;

   assign head       = rsp_q_ff[rd_ptr_ff];
   assign rsp_tvalid = (q_cnt_ff != '0);
   assign rsp_tdata  = head.hit ? PIX_ON : PIX_OFF;
   assign rsp_tlast  = head.frame_end;

endmodule

// ===== tb/sv/disc_morph_checker.sv =====
// Predicts the disc erosion/dilation result stream and checks every result transfer against it.
`timescale 1ns / 100ps
module disc_morph_checker
   import bmd_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data,
   output int          results_due,
   output int          mismatch_count
);

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_end;
   } out_pixel_t;

   logic        mode_q;
   logic [10:0] width_q;
   logic [10:0] height_q;
   bit          row_hist [0:3][0:MAX_WIDTH-1];
   logic [24:0] window_q;
   int          col_pos;
   int          row_pos;
   out_pixel_t  pending_pixels [$];

   function automatic int clamp_size(logic [10:0] v, int hi);
      int s;
      s = int'(v);
      if (s < MIN_SIZE) s = MIN_SIZE;
      if (s > hi) s = hi;
      return s;
   endfunction

   function automatic bit interior(int y, int x, int h, int w);
      return x >= 2 && x <= w - 3 && y >= 2 && y <= h - 3;
   endfunction

   task automatic restart_frame();
      col_pos = 0;
      row_pos = 0;
   endtask

   // Shift one item into the line history and window; queue the result pixel it completes.
   task automatic shift_in_pixel(input logic [7:0] pix, input logic pad);
      int         w;
      int         h;
      int         c;
      int         pos;
      int         cy;
      int         cx;
      bit         in_bit;
      bit         hit;
      bit         last;
      logic [4:0] column;
      out_pixel_t entry;
      w = clamp_size(width_q, MAX_WIDTH);
      h = clamp_size(height_q, MAX_HEIGHT);
      if (col_pos >= w || row_pos > h + 2) restart_frame();
      if (!pad) begin
         if (row_pos >= h) restart_frame();
         in_bit = (mode_q == MODE_DILATE) ? (pix != PIX_OFF) : (pix == PIX_ON);
      end else begin
         // pads only count once the frame's rows are all in
         if (row_pos < h) return;
         in_bit = 1'b0;
      end
      c = col_pos;
      column = {in_bit, row_hist[0][c], row_hist[1][c], row_hist[2][c], row_hist[3][c]};
      row_hist[3][c] = row_hist[2][c];
      row_hist[2][c] = row_hist[1][c];
      row_hist[1][c] = row_hist[0][c];
      row_hist[0][c] = in_bit;
      window_q = {window_q[19:0], column};
      pos = row_pos * w + c;
      if (c >= 2) begin
         cy = row_pos - 2;
         cx = c - 2;
      end else begin
         cy = row_pos - 3;
         cx = c + w - 2;
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (pos < 2 * w + 2) return;
      if (mode_q == MODE_ERODE) begin
         hit = interior(cy, cx, h, w);
         for (int dy = -2; dy <= 2; dy++)
            for (int dx = -2; dx <= 2; dx++) begin
               if (dy * dy == 4 && dx * dx == 4) continue;
               if (!window_q[(2 - dx) * 5 + dy + 2]) hit = 1'b0;
            end
      end else begin
         hit = 1'b0;
         for (int dy = -2; dy <= 2; dy++)
            for (int dx = -2; dx <= 2; dx++) begin
               if (dy * dy == 4 && dx * dx == 4) continue;
               if (interior(cy + dy, cx + dx, h, w) && window_q[(2 - dx) * 5 + dy + 2])
                  hit = 1'b1;
            end
      end
      last = (cy == h - 1) && (cx == w - 1);
      if (last) restart_frame();
      entry.pixel     = hit ? PIX_ON : PIX_OFF;
      entry.frame_end = last;
      pending_pixels.push_back(entry);
   endtask

   always @(posedge clock) begin : monitor
      out_pixel_t want;
      if (reset) begin
         foreach (row_hist[i, j]) row_hist[i][j] = 1'b0;
         window_q = '0;
         restart_frame();
         mode_q   = MODE_ERODE;
         width_q  = FRAME_WIDTH_RST;
         height_q = FRAME_HEIGHT_RST;
         pending_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               $error("unexpected result: pixel_out %0d frame_end %0b", rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_tdata !== want.pixel) begin
                  $error("pixel_out mismatch: expected %0d, actual %0d", want.pixel, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.frame_end) begin
                  $error("frame_end mismatch: expected %0b, actual %0b",
                         want.frame_end, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OP_MODE:      mode_q   = csr_data[0];
               CSR_FRAME_WIDTH:  width_q  = csr_data;
               CSR_FRAME_HEIGHT: height_q = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) shift_in_pixel(req_tdata, req_tuser);
      end
      results_due = pending_pixels.size();
   end

endmodule

// ===== tb/sv/binary_morphology_disc5x5_tb.sv =====
// Top of the disc morphology testbench: clock, reset, stimulus, result back-pressure, verdict.
`timescale 1ns / 100ps
module binary_morphology_disc5x5_tb;
   import bmd_pkg::*;

   localparam int LINE_MAX        = 1024;
   localparam int ROWS_MAX        = 1024;
   localparam int RANDOM_ITEMS    = 750;
   // trailing items pass the stage 1 registers and the output queue; leave margin
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 400;
   // At most about 2.2k items; the limit covers every item paying the longest send gap and
   // the longest result stall, plus the long hold-off, with ample margin.
   localparam int CYCLE_LIMIT     = 1_000_000;
   // index with no register behind it; writes there must change nothing
   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] pixel_in
   logic        req_tuser  = 1'b0; // [0] pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] pixel_out
   logic        rsp_tlast;         // frame_end
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = CSR_OP_MODE;
   logic [10:0] csr_data   = '0;

   int results_due;
   int mismatch_count;
   int sent_items     = 0;
   int cycle_count    = 0;
   bit hold_requested = 1'b0;

   binary_morphology_disc5x5 #(
      .MAX_WIDTH  (LINE_MAX),
      .MAX_HEIGHT (ROWS_MAX)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   disc_morph_checker #(
      .MAX_WIDTH  (LINE_MAX),
      .MAX_HEIGHT (ROWS_MAX)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .results_due    (results_due),
      .mismatch_count (mismatch_count)
   );

   // 20 ns period
   always #10 clock = ~clock;

   // Watchdog: end the run if the stream ever hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Pixel with roughly on_pct percent set. Values strictly between 0 and 255 count as set
   // only when dilating, so mix them in on both sides.
   function automatic logic [7:0] pick_pixel(int on_pct);
      if ($urandom_range(0, 99) < on_pct)
         return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 254)) : PIX_ON;
      return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 254)) : PIX_OFF;
   endfunction

   // Frame size the block actually uses for a register value.
   function automatic int fit_size(logic [10:0] v, int hi);
      int s;
      s = int'(v);
      if (s < MIN_SIZE) s = MIN_SIZE;
      if (s > hi) s = hi;
      return s;
   endfunction

   // Offer one item and hold it until the transfer. Called and returns at a falling edge with
   // tvalid still high, so back-to-back items never lower and raise it in the same step.
   task automatic send_item(input logic [7:0] pix, input logic pad);
      int gap;
      // every 160 items, run 40 without any gaps
      gap = (sent_items % 160 < 40) ? 0 : pick_gap();
      sent_items++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= pad;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // One register write; returns with csr_valid low, so it drops before the next write.
   task automatic write_reg(input logic [1:0] index, input logic [10:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Drop tvalid, wait for every predicted result, then let trailing no-result items retire.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Raster frame with the odd stray pad inside it, followed by flush_pads pad items.
   // A full flush is 2*w+2 pads; fewer means the next pixel cuts the frame's tail off.
   task automatic send_frame(input int w, input int h, input int on_pct, input int flush_pads);
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(0, 29) == 0) send_item(8'($urandom), 1'b1);
         send_item(pick_pixel(on_pct), 1'b0);
      end
      repeat (flush_pads) send_item(8'($urandom), 1'b1);
   endtask

   // Result side: random stalls with quiet stretches, plus one long hold-off on request so
   // the three-entry output queue fills and the block has to drop req_tready.
   initial begin : result_sink
      int n;
      int hold;
      bit hold_done;
      n         = 0;
      hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_requested && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            hold = (n % 64 < 12) ? 0 : pick_gap();
            n++;
            if (hold > 0) begin
               rsp_tready <= 1'b0;
               repeat (hold) @(negedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int          phase;
      int          base;
      int          random_items;
      int          n_frames;
      int          w;
      int          h;
      int          r;
      int          on_pct;
      bit          big_phase;
      logic        mode;
      logic [10:0] w_reg;
      logic [10:0] h_reg;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // pad with no frame under way: dropped
      send_item(PIX_ON, 1'b1);
      // pixel extremes inside the default 640-wide frame; far too early for any result
      send_item(PIX_OFF, 1'b0);
      send_item(PIX_ON, 1'b0);
      send_item(8'd1, 1'b0);
      send_item(8'd254, 1'b0);
      send_item(8'h80, 1'b1);   // pad mid-frame: dropped
      send_item(8'h7F, 1'b0);
      settle();
      // Shrink the line under the five columns already taken: the next pixel restarts the
      // frame at its origin. Both sizes are below the floor and saturate to five.
      write_reg(CSR_FRAME_WIDTH, 11'd0);
      write_reg(CSR_FRAME_HEIGHT, 11'd3);
      write_reg(CSR_OP_MODE, {10'd0, MODE_ERODE});
      write_reg(CSR_SPARE, 11'h7FF);
      // solid 5x5 frame: erosion keeps only the center pixel
      repeat (25) send_item(PIX_ON, 1'b0);
      repeat (12) send_item(8'h00, 1'b1);

      // --- random part ---
      // Phases 1 and 3 run a short noise burst at sizes above the ceiling: the widest line
      // (saturates), then the tallest frame (saturates). Other phases stay small.
      random_items = 0;
      phase        = 0;
      while (random_items < RANDOM_ITEMS) begin
         settle();
         big_phase = (phase == 1) || (phase == 3);
         mode      = 1'($urandom_range(0, 1));
         if (phase == 1) begin
            w_reg = 11'h7FF;
            h_reg = 11'd5;
         end else if (phase == 3) begin
            w_reg = 11'd5;
            h_reg = 11'h7FF;
         end else begin
            r = $urandom_range(0, 9);
            w_reg = (r == 0) ? 11'($urandom_range(0, 4)) :
                    (r < 7)  ? 11'($urandom_range(5, 10)) :
                    (r < 9)  ? 11'($urandom_range(11, 20)) : 11'($urandom_range(21, 40));
            h_reg = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 4)) :
                                                  11'($urandom_range(5, 9));
         end
         // upper data bits are don't-care for the mode register
         write_reg(CSR_OP_MODE, {10'($urandom), mode});
         write_reg(CSR_FRAME_WIDTH, w_reg);
         write_reg(CSR_FRAME_HEIGHT, h_reg);
         // first phase: ask the result side for its long hold-off while items keep coming
         if (phase == 0) hold_requested = 1'b1;
         w = fit_size(w_reg, LINE_MAX);
         h = fit_size(h_reg, ROWS_MAX);
         // dense frames for erosion, sparse ones for dilation, so both give mixed output
         on_pct = (mode == MODE_ERODE) ? $urandom_range(80, 97) : $urandom_range(3, 25);
         base     = sent_items;
         n_frames = big_phase ? 1 : $urandom_range(1, 3);
         repeat (n_frames) begin
            // the hold-off phase always sends full frames so results pile up behind it
            r = (phase == 0) ? 0 : big_phase ? 99 : $urandom_range(0, 99);
            if (r < 75) begin
               // full flush, sometimes with stray pads after it (dropped)
               send_frame(w, h, on_pct,
                          2 * w + 2 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0));
            end else if (r < 88) begin
               // short flush: the next pixel starts a new frame and drops the tail
               send_frame(w, h, on_pct, $urandom_range(0, 2 * w + 1));
            end else begin
               // noise: random pixels and pads in any order
               repeat ($urandom_range(10, 40)) send_item(8'($urandom), 1'($urandom));
            end
         end
         random_items += sent_items - base;
         phase++;
      end

      settle();
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/bmd_pkg.sv
design/bmd_ram.sv
design/binary_morphology_disc5x5.sv
tb/sv/disc_morph_checker.sv
tb/sv/binary_morphology_disc5x5_tb.sv
